// ===== rtl/timing_channel_bit_receiver_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the timing-channel bit receiver
// Shared property forms with a clock and an active-low reset.
// ----------------------------------------------------------------------------
`ifndef TIMING_CHANNEL_BIT_RECEIVER_TOP_ASSERT_SVH
`define TIMING_CHANNEL_BIT_RECEIVER_TOP_ASSERT_SVH

// Same-cycle implication.
`define TCBR_ASSERT_NOW(label, clk, rstn, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication.
`define TCBR_ASSERT_NEXT(label, clk, rstn, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ===== rtl/tcbr_pkg.sv =====
// ----------------------------------------------------------------------------
// tcbr_pkg
// Types and constants shared by the timing-channel bit receiver modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tcbr_pkg;

    localparam int COUNT_BITS_DEF  = 16;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam int LAT_W  = 16;
    localparam int LEN_W  = 8;
    localparam int BYTE_W = 8;
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam logic [LAT_W-1:0] MISS_THRESHOLD_RST = 16'd215;
    localparam logic [LEN_W-1:0] SYNC_LENGTH_RST    = 8'd8;
    localparam logic [LEN_W-1:0] END_LENGTH_RST     = 8'd17;

    // Raw bits per vote minus one: the last raw bit of a triple.
    localparam logic [1:0] VOTE_LAST_IDX = 2'd2;

    typedef enum logic [1:0] {
        REG_MISS_THRESHOLD = 2'd0,
        REG_SYNC_LENGTH    = 2'd1,
        REG_END_LENGTH     = 2'd2,
        REG_UNUSED         = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

endpackage

// ===== rtl/tcbr_vote_queue.sv =====
// ----------------------------------------------------------------------------
// tcbr_vote_queue
// Short queue of decoded votes between the sampling front and the byte back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcbr_vote_queue
    import tcbr_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push,
    input  logic        push_vote,
    input  logic        pop,
    output logic        pop_vote,
    output queue_stat_t stat
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [DEPTH-1:0] slot_reg;
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_vote;
        end
    end

    assign pop_vote   = slot_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == FULL_CNT);
    assign stat.empty = (count_reg == '0);

endmodule

// ===== rtl/tcbr_front.sv =====
// ----------------------------------------------------------------------------
// tcbr_front
// Classifies probe samples as hit or miss, forms raw bits and majority votes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcbr_front
    import tcbr_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [LAT_W-1:0] miss_threshold,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [LAT_W-1:0] s_latency,
    input  logic             s_window_last,
    input  queue_stat_t      q_stat,
    output logic             vote_push,
    output logic             vote_value
);

    logic [COUNT_BITS-1:0] hit_reg, hit_next;
    logic [COUNT_BITS-1:0] miss_reg, miss_next;
    logic [1:0]            vbits_reg, vbits_next;
    logic [1:0]            vidx_reg, vidx_next;

    logic [COUNT_BITS-1:0] hit_upd, miss_upd;
    logic                  take, is_hit, raw_bit;
    logic [1:0]            ones;

    assign s_ready = !q_stat.full;
    assign take    = s_valid && s_ready;
    assign is_hit  = (s_latency < miss_threshold);

    always_comb begin
        hit_upd  = hit_reg;
        miss_upd = miss_reg;
        if (is_hit) begin
            hit_upd = (&hit_reg) ? hit_reg : hit_reg + 1'b1;
        end else begin
            miss_upd = (&miss_reg) ? miss_reg : miss_reg + 1'b1;
        end
    end

    assign raw_bit = !(hit_upd < miss_upd);
    assign ones    = {1'b0, vbits_reg[0]} + {1'b0, vbits_reg[1]} + {1'b0, raw_bit};

    always_comb begin
        hit_next   = hit_reg;
        miss_next  = miss_reg;
        vbits_next = vbits_reg;
        vidx_next  = vidx_reg;
        vote_push  = 1'b0;
        vote_value = ones[1];
        if (take) begin
            hit_next  = hit_upd;
            miss_next = miss_upd;
            if (s_window_last) begin
                hit_next  = '0;
                miss_next = '0;
                if (vidx_reg < VOTE_LAST_IDX) begin
                    vbits_next = vbits_reg | ({1'b0, raw_bit} << vidx_reg[0]);
                    vidx_next  = vidx_reg + 1'b1;
                end else begin
                    // third raw bit: vote and clear the triple
                    vbits_next = '0;
                    vidx_next  = '0;
                    vote_push  = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_reg   <= '0;
            miss_reg  <= '0;
            vbits_reg <= '0;
            vidx_reg  <= '0;
        end else begin
            hit_reg   <= hit_next;
            miss_reg  <= miss_next;
            vbits_reg <= vbits_next;
            vidx_reg  <= vidx_next;
        end
    end

endmodule

// ===== rtl/tcbr_back.sv =====
// ----------------------------------------------------------------------------
// tcbr_back
// Consumes votes: sync detection, byte assembly and end-of-message marker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcbr_back
    import tcbr_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [LEN_W-1:0]  sync_length,
    input  logic [LEN_W-1:0]  end_length,
    input  queue_stat_t       q_stat,
    input  logic              vote_value,
    output logic              vote_pop,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [BYTE_W-1:0] m_byte_out,
    output logic              m_message_end
);

    logic [LEN_W-1:0]  zrun_reg, zrun_next;
    logic              locked_reg, locked_next;
    logic [BYTE_W-1:0] shift_reg, shift_next;
    logic [2:0]        bidx_reg, bidx_next;
    logic              done_reg, done_next;
    logic              ovalid_reg, ovalid_next;
    logic [BYTE_W-1:0] obyte_reg, obyte_next;
    logic              oend_reg, oend_next;

    logic              slot_free;
    logic [LEN_W-1:0]  zrun_inc;
    logic [BYTE_W-1:0] shifted;

    assign slot_free = !ovalid_reg || m_ready;
    // drain without output once the message has ended
    assign vote_pop  = !q_stat.empty && (done_reg || slot_free);
    assign zrun_inc  = (&zrun_reg) ? zrun_reg : zrun_reg + 1'b1;
    assign shifted   = {shift_reg[BYTE_W-2:0], vote_value};

    always_comb begin
        zrun_next   = zrun_reg;
        locked_next = locked_reg;
        shift_next  = shift_reg;
        bidx_next   = bidx_reg;
        done_next   = done_reg;
        ovalid_next = ovalid_reg && !m_ready;
        obyte_next  = obyte_reg;
        oend_next   = oend_reg;
        if (vote_pop && !done_reg) begin
            if (!locked_reg) begin
                if (!vote_value) begin
                    zrun_next = zrun_inc;
                    if (zrun_inc >= sync_length) begin
                        locked_next = 1'b1;
                        zrun_next   = '0;
                    end
                end else begin
                    zrun_next = '0;
                end
            end else if (!vote_value && (zrun_inc >= end_length)) begin
                zrun_next   = zrun_inc;
                done_next   = 1'b1;
                ovalid_next = 1'b1;
                obyte_next  = '0;
                oend_next   = 1'b1;
            end else begin
                zrun_next  = vote_value ? '0 : zrun_inc;
                shift_next = shifted;
                bidx_next  = bidx_reg + 1'b1;
                if (&bidx_reg) begin
                    shift_next  = '0;
                    ovalid_next = 1'b1;
                    obyte_next  = shifted;
                    oend_next   = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zrun_reg   <= '0;
            locked_reg <= 1'b0;
            shift_reg  <= '0;
            bidx_reg   <= '0;
            done_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end else begin
            zrun_reg   <= zrun_next;
            locked_reg <= locked_next;
            shift_reg  <= shift_next;
            bidx_reg   <= bidx_next;
            done_reg   <= done_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        obyte_reg <= obyte_next;
        oend_reg  <= oend_next;
    end

    assign m_valid       = ovalid_reg;
    assign m_byte_out    = obyte_reg;
    assign m_message_end = oend_reg;

endmodule

// ===== rtl/timing_channel_bit_receiver_top.sv =====
// ----------------------------------------------------------------------------
// timing_channel_bit_receiver_top
// Probe-latency receiver: hit/miss windows, triple majority vote, sync and
// byte framing, with an APB register port.
//
//   Channel | Ports                          | Transfer
//   --------+--------------------------------+------------------------------
//   in      | s_latency, s_window_last       | s_valid & s_ready
//   out     | m_byte_out, m_message_end      | m_valid & m_ready
//   config  | psel/penable/pwrite/paddr/...  | access phase, pready high
//
// One sample per cycle: the front compares and counts in the transaction
// cycle and pushes a vote into the queue on every third window end.
// The back retires one vote per cycle unless a held result stalls it;
// m_valid comes from the back's output register, behind the vote queue.
// s_ready drops only while the vote queue is full, which happens only while
// m_ready holds a result back. Reset is synchronous; no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "timing_channel_bit_receiver_top_assert.svh"

module timing_channel_bit_receiver_top
    import tcbr_pkg::*;
#(
    parameter int COUNT_BITS  = COUNT_BITS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [LAT_W-1:0]  s_latency,
    input  logic              s_window_last,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [BYTE_W-1:0] m_byte_out,
    output logic              m_message_end
);

    logic [LAT_W-1:0] thresh_reg, thresh_next;
    logic [LEN_W-1:0] sync_reg, sync_next;
    logic [LEN_W-1:0] end_reg, end_next;

    reg_idx_t    reg_idx;
    logic        wr_en;
    queue_stat_t q_stat;
    logic        vote_push, vote_in, vote_pop, vote_out;

    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite && pready;

    always_comb begin
        thresh_next = thresh_reg;
        sync_next   = sync_reg;
        end_next    = end_reg;
        if (wr_en) begin
            case (reg_idx)
                REG_MISS_THRESHOLD: thresh_next = pwdata[LAT_W-1:0];
                REG_SYNC_LENGTH:    sync_next   = pwdata[LEN_W-1:0];
                REG_END_LENGTH:     end_next    = pwdata[LEN_W-1:0];
                default: begin
                    // drop writes to unmapped addresses
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_MISS_THRESHOLD: prdata = {{(DATA_W-LAT_W){1'b0}}, thresh_reg};
            REG_SYNC_LENGTH:    prdata = {{(DATA_W-LEN_W){1'b0}}, sync_reg};
            REG_END_LENGTH:     prdata = {{(DATA_W-LEN_W){1'b0}}, end_reg};
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thresh_reg <= MISS_THRESHOLD_RST;
            sync_reg   <= SYNC_LENGTH_RST;
            end_reg    <= END_LENGTH_RST;
        end else begin
            thresh_reg <= thresh_next;
            sync_reg   <= sync_next;
            end_reg    <= end_next;
        end
    end

    tcbr_front #(
        .COUNT_BITS(COUNT_BITS)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .miss_threshold(thresh_reg),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_latency     (s_latency),
        .s_window_last (s_window_last),
        .q_stat        (q_stat),
        .vote_push     (vote_push),
        .vote_value    (vote_in)
    );

    tcbr_vote_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (vote_push),
        .push_vote(vote_in),
        .pop      (vote_pop),
        .pop_vote (vote_out),
        .stat     (q_stat)
    );

    tcbr_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .sync_length  (sync_reg),
        .end_length   (end_reg),
        .q_stat       (q_stat),
        .vote_value   (vote_out),
        .vote_pop     (vote_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_byte_out   (m_byte_out),
        .m_message_end(m_message_end)
    );

    `TCBR_ASSERT_NOW(a_no_overflow, aclk, aresetn, vote_push, !q_stat.full,
        "vote pushed into a full queue")
    `TCBR_ASSERT_NOW(a_no_underflow, aclk, aresetn, vote_pop, !q_stat.empty,
        "vote popped from an empty queue")
    `TCBR_ASSERT_NOW(a_end_zero, aclk, aresetn, m_valid && m_message_end,
        m_byte_out == '0, "end marker carries a nonzero byte")
    `TCBR_ASSERT_NEXT(a_silent_after_end, aclk, aresetn,
        m_valid && m_ready && m_message_end, !m_valid,
        "result produced after the end marker")

endmodule
